@@ hw/rtl/tpa_pkg.sv @@
`default_nettype none

package tpa_pkg;

   localparam int unsigned QUEUE_DEPTH = 16;
   localparam int unsigned HALF_WIDTH  = 64;
   localparam int unsigned FLIT_WIDTH  = 2 * HALF_WIDTH;

   // packet length field in the header flit
   localparam int unsigned LEN_MSB   = 11;
   localparam int unsigned LEN_LSB   = 7;
   localparam int unsigned LEN_WIDTH = LEN_MSB - LEN_LSB + 1;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_HOST = 2'd1,
      MODE_PIM  = 2'd2
   } tpa_mode_type;

   typedef struct packed {
      logic empty;
      logic full;
   } tpa_queue_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/tpa_queue.sv @@
`default_nettype none

module tpa_queue #(
   parameter int unsigned QUEUE_DEPTH = tpa_pkg::QUEUE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   input  wire logic                                pop,
   input  wire logic [tpa_pkg::FLIT_WIDTH-1:0]      push_flit,
   output logic      [tpa_pkg::FLIT_WIDTH-1:0]      head_flit,
   output tpa_pkg::tpa_queue_status_type            status
);

   localparam int unsigned ADDR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int unsigned COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [ADDR_WIDTH-1:0]  LAST_ADDR = ADDR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(QUEUE_DEPTH);

   logic [tpa_pkg::FLIT_WIDTH-1:0] mem [QUEUE_DEPTH];

   logic [ADDR_WIDTH-1:0]          rd_ff, rd_in;
   logic [ADDR_WIDTH-1:0]          wr_ff, wr_in;
   logic [COUNT_WIDTH-1:0]         count_ff, count_in;
   logic [tpa_pkg::FLIT_WIDTH-1:0] head_ff;

   always_comb begin
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      count_in = count_ff;
      if (pop) begin
         rd_in = (rd_ff == LAST_ADDR) ? '0 : rd_ff + 1'b1;
      end
      if (push) begin
         wr_in = (wr_ff == LAST_ADDR) ? '0 : wr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   // head register reads ahead at the next read pointer; a write to that
   // same slot in this cycle is forwarded
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_flit;
      end
      if (push && (wr_ff == rd_in)) begin
         head_ff <= push_flit;
      end else begin
         head_ff <= mem[rd_in];
      end
   end

   assign head_flit    = head_ff;
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_COUNT);

endmodule

`default_nettype wire

@@ hw/rtl/two_source_packet_arbiter_core.sv @@
`default_nettype none

// Channel   Dir  Ports            Contents
// req       in   req_t*           one clock tick: optional host flit, optional PIM flit
// rsp       out  rsp_t*           one result per request: sent flit, drop flags
//
// Every accepted request yields exactly one response, registered, in the next cycle.
// A new request is taken every cycle while the response register is free or
// being drained; throughput is set by that single output register.
// req_tready drops only while a response is held and rsp_tready is low.
// Synchronous active-high reset clears pointers, counts, mode, turn and the
// length counter; queue storage is left as is (no clearing pass).

module two_source_packet_arbiter_core #(
   parameter int unsigned QUEUE_DEPTH = tpa_pkg::QUEUE_DEPTH
) (
   input  wire logic           clock,
   input  wire logic           reset,

   input  wire logic           req_tvalid,
   output logic                req_tready,
   // [63:0] host_flit_low, [127:64] host_flit_high,
   // [191:128] pim_flit_low, [255:192] pim_flit_high
   input  wire logic [255:0]   req_tdata,
   // [0] host_valid, [1] pim_valid
   input  wire logic [1:0]     req_tuser,

   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   // [63:0] out_flit_low, [127:64] out_flit_high
   output logic [127:0]        rsp_tdata,
   // [0] out_valid, [1] host_dropped, [2] pim_dropped
   output logic [2:0]          rsp_tuser
);

   localparam int unsigned FW = tpa_pkg::FLIT_WIDTH;
   localparam int unsigned LW = tpa_pkg::LEN_WIDTH;

   logic          fire;
   logic          host_valid, pim_valid;
   logic [FW-1:0] host_flit, pim_flit;

   logic [FW-1:0] host_head, pim_head;
   tpa_pkg::tpa_queue_status_type host_status, pim_status;

   tpa_pkg::tpa_mode_type mode_ff, mode_in;
   logic          turn_ff, turn_in;          // 0: host next, 1: PIM next
   logic [LW-1:0] left_ff, left_in;          // flits still owed in this packet

   logic          host_pop, pim_pop;
   logic          host_push, pim_push;
   logic          host_drop, pim_drop;
   logic          send_valid;
   logic [FW-1:0] send_flit;
   logic [FW-1:0] sel_head;
   logic          sel_empty;
   logic [LW-1:0] start_len, send_len;

   logic          rsp_valid_ff;
   logic [FW-1:0] rsp_data_ff;
   logic [2:0]    rsp_user_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;

   assign host_valid = req_tuser[0];
   assign pim_valid  = req_tuser[1];
   assign host_flit  = req_tdata[FW-1:0];
   assign pim_flit   = req_tdata[2*FW-1:FW];

   tpa_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_host_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire && host_push),
      .pop       (fire && host_pop),
      .push_flit (host_flit),
      .head_flit (host_head),
      .status    (host_status)
   );

   tpa_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_pim_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire && pim_push),
      .pop       (fire && pim_pop),
      .push_flit (pim_flit),
      .head_flit (pim_head),
      .status    (pim_status)
   );

   // queue currently being drained
   assign sel_head  = (mode_ff == tpa_pkg::MODE_PIM) ? pim_head : host_head;
   assign sel_empty = (mode_ff == tpa_pkg::MODE_PIM) ? pim_status.empty : host_status.empty;

   // header length, zero taken as a single flit
   always_comb begin
      start_len = sel_head[tpa_pkg::LEN_MSB:tpa_pkg::LEN_LSB];
      if (start_len == '0) begin
         start_len = LW'(1);
      end
      send_len = (left_ff == '0) ? start_len : left_ff;
   end

   // arbiter: acts on queue contents from earlier ticks
   always_comb begin
      mode_in    = mode_ff;
      turn_in    = turn_ff;
      left_in    = left_ff;
      host_pop   = 1'b0;
      pim_pop    = 1'b0;
      send_valid = 1'b0;
      send_flit  = '0;
      unique case (mode_ff)
         tpa_pkg::MODE_HOST, tpa_pkg::MODE_PIM: begin
            // empty queue mid-packet: stall with nothing sent
            if (!sel_empty) begin
               send_valid = 1'b1;
               send_flit  = sel_head;
               host_pop   = (mode_ff == tpa_pkg::MODE_HOST);
               pim_pop    = (mode_ff == tpa_pkg::MODE_PIM);
               left_in    = send_len - 1'b1;
               if (send_len == LW'(1)) begin
                  mode_in = tpa_pkg::MODE_IDLE;
               end
            end
         end
         default: begin
            // idle (and the unused code): pick a source, send from next tick
            left_in = '0;
            mode_in = tpa_pkg::MODE_IDLE;
            if (!host_status.empty && pim_status.empty) begin
               mode_in = tpa_pkg::MODE_HOST;
            end else if (host_status.empty && !pim_status.empty) begin
               mode_in = tpa_pkg::MODE_PIM;
            end else if (!host_status.empty && !pim_status.empty) begin
               mode_in = turn_ff ? tpa_pkg::MODE_PIM : tpa_pkg::MODE_HOST;
               turn_in = !turn_ff;
            end
         end
      endcase
   end

   // arriving flits go in after this tick's send; a queue still full after it drops them
   assign host_drop = host_valid && host_status.full && !host_pop;
   assign pim_drop  = pim_valid && pim_status.full && !pim_pop;
   assign host_push = host_valid && !host_drop;
   assign pim_push  = pim_valid && !pim_drop;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tpa_pkg::MODE_IDLE;
         turn_ff <= 1'b0;
         left_ff <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         turn_ff <= turn_in;
         left_ff <= left_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= send_flit;
         rsp_user_ff <= {pim_drop, host_drop, send_valid};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tpa_checker.sv @@
`default_nettype none

module tpa_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [127:0] rsp_tdata,
   input wire logic [2:0]   rsp_tuser
);

   // held response stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response withdrawn while stalled");

   // every accepted request yields a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no response");

   // a response being drained frees the input side
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |-> req_tready)
      else $error("input stalled while output drains");

   // no flit sent means zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("data present without a sent flit");

   // nothing pending right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind two_source_packet_arbiter_core tpa_checker u_tpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

@@ test/tpa_flit_checker.sv @@
`default_nettype none

// Watches both channels of the arbiter, predicts the vault-side response of
// every accepted request and compares it field by field in arrival order.
module tpa_flit_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [255:0] req_tdata,
   input  wire logic [1:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [127:0] rsp_tdata,
   input  wire logic [2:0]   rsp_tuser,
   output logic [31:0]       failures,
   output logic [31:0]       outstanding
);

   localparam int SRC_HOST = 0;
   localparam int SRC_PIM  = 1;
   localparam int unsigned HW = tpa_pkg::HALF_WIDTH;
   localparam int unsigned FW = tpa_pkg::FLIT_WIDTH;
   localparam int unsigned LW = tpa_pkg::LEN_WIDTH;
   localparam int unsigned PTR_WIDTH = $clog2(tpa_pkg::QUEUE_DEPTH);
   localparam logic [PTR_WIDTH-1:0] LAST_SLOT = PTR_WIDTH'(tpa_pkg::QUEUE_DEPTH - 1);

   typedef struct packed {
      logic          sent;
      logic [HW-1:0] flit_low;
      logic [HW-1:0] flit_high;
      logic          host_lost;
      logic          pim_lost;
   } vault_beat_type;

   // per-source flit queues, indexed [source][slot]
   logic [HW-1:0]          q_low  [2][tpa_pkg::QUEUE_DEPTH];
   logic [HW-1:0]          q_high [2][tpa_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   q_rd [2];
   logic [PTR_WIDTH-1:0]   q_wr [2];
   int                     q_fill [2];
   tpa_pkg::tpa_mode_type  arb_mode;
   logic                   pim_turn;
   logic [LW-1:0]          flits_left;

   vault_beat_type expected_beats [$];
   int             mismatch_count = 0;
   int             beats_waiting = 0;

   assign failures    = mismatch_count;
   assign outstanding = beats_waiting;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // one clock tick of the arbiter: send first, then queue the arrivals
   task automatic predict_vault_beat(input logic [1:0] offered,
                                     input logic [255:0] payload,
                                     output vault_beat_type beat);
      int   src;
      logic have_host;
      logic have_pim;
      beat = '0;
      if (arb_mode == tpa_pkg::MODE_HOST || arb_mode == tpa_pkg::MODE_PIM) begin
         src = (arb_mode == tpa_pkg::MODE_HOST) ? SRC_HOST : SRC_PIM;
         // empty queue: stall with nothing sent
         if (q_fill[src] != 0) begin
            if (flits_left == '0) begin
               flits_left = q_low[src][q_rd[src]][tpa_pkg::LEN_MSB:tpa_pkg::LEN_LSB];
               if (flits_left == '0)
                  flits_left = LW'(1);   // zero length counts as one flit
            end
            beat.sent      = 1'b1;
            beat.flit_low  = q_low[src][q_rd[src]];
            beat.flit_high = q_high[src][q_rd[src]];
            q_rd[src]      = (q_rd[src] == LAST_SLOT) ? '0 : q_rd[src] + 1'b1;
            q_fill[src]--;
            flits_left--;
            if (flits_left == '0)
               arb_mode = tpa_pkg::MODE_IDLE;
         end
      end else begin
         have_host  = q_fill[SRC_HOST] != 0;
         have_pim   = q_fill[SRC_PIM] != 0;
         arb_mode   = tpa_pkg::MODE_IDLE;
         flits_left = '0;
         if (have_host && !have_pim) begin
            arb_mode = tpa_pkg::MODE_HOST;
         end else if (!have_host && have_pim) begin
            arb_mode = tpa_pkg::MODE_PIM;
         end else if (have_host && have_pim) begin
            arb_mode = pim_turn ? tpa_pkg::MODE_PIM : tpa_pkg::MODE_HOST;
            pim_turn = !pim_turn;
         end
      end
      for (int s = 0; s < 2; s++) begin
         if (offered[s]) begin
            if (q_fill[s] >= tpa_pkg::QUEUE_DEPTH) begin
               if (s == SRC_HOST)
                  beat.host_lost = 1'b1;
               else
                  beat.pim_lost = 1'b1;
            end else begin
               q_low[s][q_wr[s]]  = payload[s*FW +: HW];
               q_high[s][q_wr[s]] = payload[s*FW + HW +: HW];
               q_wr[s]            = (q_wr[s] == LAST_SLOT) ? '0 : q_wr[s] + 1'b1;
               q_fill[s]++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      vault_beat_type want;
      vault_beat_type seen;
      if (reset) begin
         for (int s = 0; s < 2; s++) begin
            q_rd[s]   = '0;
            q_wr[s]   = '0;
            q_fill[s] = 0;
         end
         arb_mode   = tpa_pkg::MODE_IDLE;
         pim_turn   = 1'b0;
         flits_left = '0;
         expected_beats.delete();
         beats_waiting = 0;
      end else begin
         // a response never leaves in the cycle its request is accepted: pop before push
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tuser[0], rsp_tdata[63:0], rsp_tdata[127:64],
                    rsp_tuser[1], rsp_tuser[2]};
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata[63:0], 64'h0);
            end else begin
               want = expected_beats.pop_front();
               beats_waiting--;
               if (seen.sent != want.sent)
                  report_mismatch("out_valid", 64'(seen.sent), 64'(want.sent));
               if (seen.flit_low != want.flit_low)
                  report_mismatch("out_flit_low", seen.flit_low, want.flit_low);
               if (seen.flit_high != want.flit_high)
                  report_mismatch("out_flit_high", seen.flit_high, want.flit_high);
               if (seen.host_lost != want.host_lost)
                  report_mismatch("host_dropped", 64'(seen.host_lost), 64'(want.host_lost));
               if (seen.pim_lost != want.pim_lost)
                  report_mismatch("pim_dropped", 64'(seen.pim_lost), 64'(want.pim_lost));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_vault_beat(req_tuser, req_tdata, want);
            expected_beats.push_back(want);
            beats_waiting++;
         end
      end
   end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none

// Stimulus and verdict for the two-source packet arbiter. The checker beside
// the block does all prediction; this module only drives requests, throttles
// the response side and decides pass/fail.
module tb_top;

   localparam int unsigned FW = tpa_pkg::FLIT_WIDTH;
   localparam int unsigned LW = tpa_pkg::LEN_WIDTH;
   localparam logic [1:0] NO_VALID   = 2'b00;
   localparam logic [1:0] HOST_VALID = 2'b01;
   localparam logic [1:0] PIM_VALID  = 2'b10;
   localparam int SRC_HOST          = 0;
   localparam int SRC_PIM           = 1;
   localparam int RANDOM_PER_PHASE  = 225;
   localparam int HOLD_OFF_CYCLES   = 64;
   localparam int LIMIT_CYCLES      = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // [63:0] host_flit_low, [127:64] host_flit_high,
   // [191:128] pim_flit_low, [255:192] pim_flit_high
   logic [255:0] req_tdata = '0;
   // [0] host_valid, [1] pim_valid
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // [63:0] out_flit_low, [127:64] out_flit_high
   logic [127:0] rsp_tdata;
   // [0] out_valid, [1] host_dropped, [2] pim_dropped
   logic [2:0]   rsp_tuser;

   logic [31:0]  failures;
   logic [31:0]  outstanding;

   int tx_idle_pct   = 27;
   int rx_stall_pct  = 55;
   int holds_wanted  = 0;
   int holds_granted = 0;
   int cycle_count   = 0;
   // flits still owed to the packet in flight, per source
   int body_left [2] = '{0, 0};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   two_source_packet_arbiter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   tpa_flit_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // hard stop in case the block locks up
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Response side: random back-pressure, plus long hold-offs on demand so
   // the single output register fills and req_tready drops.
   initial begin
      forever begin
         @(negedge clock);
         if (holds_granted != holds_wanted) begin
            holds_granted++;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // One request: random gaps first, then hold it until accepted.
   // Entered and left on a falling edge.
   task automatic send_request(input logic [1:0] flags, input logic [255:0] data);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= flags;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering until every response is back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (outstanding != 0);
   endtask

   // Packet length for a new header: mostly short, some zero, some long.
   function automatic logic [LW-1:0] pick_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return '0;
      else if (roll < 80)
         return LW'($urandom_range(6, 1));
      else
         return LW'($urandom_range(31, 7));
   endfunction

   // Random flit for one source. Well-formed streams put a header with a
   // length at each packet start; noise flits ignore packet framing.
   task automatic next_flit(input int src, input bit noise,
                            output logic [FW-1:0] flit);
      logic [LW-1:0] len;
      flit = {$urandom, $urandom, $urandom, $urandom};
      if (!noise) begin
         if (body_left[src] == 0) begin
            len = pick_length();
            flit[tpa_pkg::LEN_MSB:tpa_pkg::LEN_LSB] = len;
            body_left[src] = (len == '0) ? 0 : int'(len) - 1;
         end else begin
            body_left[src]--;
         end
      end
   endtask

   initial begin
      int            phase;
      int            n;
      int            load;
      bit            noise;
      logic [1:0]    flags;
      logic [FW-1:0] host_flit;
      logic [FW-1:0] pim_flit;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty tick, zero-length host packet, then a long PIM packet
      // that keeps the arbiter busy while host flits pile up until dropped
      send_request(NO_VALID, '0);
      send_request(HOST_VALID, '0);
      send_request(NO_VALID, '0);
      send_request(NO_VALID, {{128{1'b1}}, 128'h0});
      send_request(PIM_VALID, {{64{1'b1}}, 64'h0000_0000_0000_0F80, 128'h0});
      for (n = 0; n < 19; n++)
         send_request(HOST_VALID | PIM_VALID,
                      {(n[0] ? {128{1'b1}} : 128'h0), {128{1'b1}}});
      drain_responses();

      // random phases: sender/receiver idling swapped, then full speed
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct  = 27;
               rx_stall_pct = 55;
            end
            1: begin
               tx_idle_pct  = 55;
               rx_stall_pct = 27;
            end
            default: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 0;
            end
         endcase
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            // offered load changes in windows so queues both fill and empty
            if (n % 50 == 0)
               load = $urandom_range(75, 15);
            if (n == 100 && phase != 1)
               holds_wanted++;
            noise = ($urandom_range(99) < 10);
            flags[SRC_HOST] = ($urandom_range(99) < load);
            flags[SRC_PIM]  = ($urandom_range(99) < load);
            host_flit = '0;
            pim_flit  = '0;
            if (flags[SRC_HOST])
               next_flit(SRC_HOST, noise, host_flit);
            if (flags[SRC_PIM])
               next_flit(SRC_PIM, noise, pim_flit);
            // idle ticks still carry random payload bits
            if (!flags[SRC_HOST])
               host_flit = {$urandom, $urandom, $urandom, $urandom};
            if (!flags[SRC_PIM])
               pim_flit = {$urandom, $urandom, $urandom, $urandom};
            send_request(flags, {pim_flit, host_flit});
         end
         drain_responses();
      end

      // let the last response settle
      repeat (4) @(negedge clock);
      if (failures == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

`default_nettype wire
